// ===== rtl/mtg_pkg.sv =====
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared constants, types and functions for the MT19937 generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mtg_pkg;

  localparam int unsigned STATE_WORDS = 624;
  localparam int unsigned TWIST_SHIFT = 397;
  localparam int unsigned POS_W       = $clog2(STATE_WORDS);

  localparam logic [31:0] TWIST_XOR = 32'h9908_b0df;
  localparam logic [31:0] HIGH_BIT  = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS  = 32'h7fff_ffff;
  localparam logic [31:0] SEED_MULT = 32'd1812433253;
  localparam logic [31:0] TEMPER_B  = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C  = 32'hefc6_0000;

  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(STATE_WORDS - 1);
  localparam logic [POS_W:0]   POS_SPAN  = (POS_W+1)'(STATE_WORDS);
  localparam logic [POS_W:0]   FAR_SHIFT = (POS_W+1)'(TWIST_SHIFT);

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [31:0]      word_t;

  // request action codes
  localparam logic ACT_SEED = 1'b0;
  localparam logic ACT_DRAW = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_SEED_MUL,
    ST_SEED_ADD
  } state_t;

  function automatic word_t twist_word(word_t cur, word_t nxt, word_t far);
    word_t joined;
    word_t mixed;
    joined = (cur & HIGH_BIT) | (nxt & LOW_BITS);
    mixed  = far ^ (joined >> 1);
    if (joined[0]) begin
      mixed = mixed ^ TWIST_XOR;
    end
    return mixed;
  endfunction

  function automatic word_t temper(word_t y_in);
    word_t y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mtg_ram.sv =====
// ----------------------------------------------------------------------------
// mtg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mtg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/mersenne_twister_generator.sv =====
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// MT19937 32-bit generator with the 624-word state held in block RAM.
// ----------------------------------------------------------------------------
// A seed request (action 0) writes word 0 with the seed and then fills words
// 1..623 by the multiply-xor recurrence, each word in a multiply step and
// then an add-index-and-write step, so a seed occupies the block for the
// whole fill and returns no result. A draw request (action 1) enters the
// draw state, which twists one word from the registered RAM read data,
// writes it back and tempers it into the output register. The twist is done
// lazily, one word per draw at the read position, which gives exactly the
// values of a full-state regeneration because the words are updated in the
// same in-place order. The state is kept twice (two RAMs written together) so
// that the next word and the word 397 ahead are read in the same cycle; the
// word at the read position itself is carried in a register from the
// previous draw or the seed write. Draws before the first seed return
// undefined data. A draw that finds an earlier result still waiting at the
// output holds in the draw state until that result is taken; a seed request
// is taken while a result waits, since it gives none.
// ----------------------------------------------------------------------------
`default_nettype none

module mersenne_twister_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [31:0] in_seed_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_random_word
);

  mtg_pkg::state_t state_r, state_nxt;
  mtg_pkg::pos_t   pos_r, pos_nxt;       // next word to twist and return
  mtg_pkg::pos_t   cnt_r, cnt_nxt;       // seed fill index
  mtg_pkg::word_t  cur_r, cur_nxt;       // old value of word at pos_r
  mtg_pkg::word_t  prev_r, prev_nxt;     // last seeded word
  mtg_pkg::word_t  prod_r, prod_nxt;     // seed product
  mtg_pkg::word_t  out_word_r, out_word_nxt;
  logic            out_valid_r, out_valid_nxt;

  // RAM ports
  logic            ram_we;
  mtg_pkg::pos_t   ram_waddr;
  mtg_pkg::word_t  ram_wdata;
  mtg_pkg::pos_t   addr_next, addr_far;
  mtg_pkg::word_t  rd_next, rd_far;

  logic [mtg_pkg::POS_W:0] far_sum;
  mtg_pkg::word_t          twisted;
  logic                    accept;

  // Read addresses follow the read position; the RAMs give the data in the next cycle.
  assign addr_next = (pos_r == mtg_pkg::POS_LAST) ? '0 : pos_r + 1'b1;
  assign far_sum   = {1'b0, pos_r} + mtg_pkg::FAR_SHIFT;
  assign addr_far  = (far_sum >= mtg_pkg::POS_SPAN)
                   ? mtg_pkg::POS_W'(far_sum - mtg_pkg::POS_SPAN)
                   : far_sum[mtg_pkg::POS_W-1:0];

  assign twisted = mtg_pkg::twist_word(cur_r, rd_next, rd_far);

  assign in_ready        = (state_r == mtg_pkg::ST_IDLE);
  assign accept          = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  mtg_ram #(
    .WIDTH(32),
    .DEPTH(mtg_pkg::STATE_WORDS)
  ) u_ram_next (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr_next),
    .rdata(rd_next)
  );

  mtg_ram #(
    .WIDTH(32),
    .DEPTH(mtg_pkg::STATE_WORDS)
  ) u_ram_far (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr_far),
    .rdata(rd_far)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtg_pkg::ST_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    prod_r     <= prod_nxt;
    out_word_r <= out_word_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    prod_nxt      = prod_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = prod_r + 32'(cnt_r);

    case (state_r)
      mtg_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_action == mtg_pkg::ACT_SEED) begin
            // word 0 is the seed itself
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = in_seed_value;
            prev_nxt  = in_seed_value;
            cur_nxt   = in_seed_value;
            cnt_nxt   = mtg_pkg::POS_W'(1);
            pos_nxt   = '0;
            state_nxt = mtg_pkg::ST_SEED_MUL;
          end else begin
            state_nxt = mtg_pkg::ST_DRAW;
          end
        end
      end

      mtg_pkg::ST_DRAW: begin
        if (out_valid_r && !out_ready) begin
          // earlier result still waiting: hold, the RAMs re-read the words for pos_r
          state_nxt = mtg_pkg::ST_DRAW;
        end else begin
          // twist word at pos_r in place, temper it for the output
          ram_we        = 1'b1;
          ram_waddr     = pos_r;
          ram_wdata     = twisted;
          cur_nxt       = rd_next;
          pos_nxt       = addr_next;
          out_word_nxt  = mtg_pkg::temper(twisted);
          out_valid_nxt = 1'b1;
          state_nxt     = mtg_pkg::ST_IDLE;
        end
      end

      mtg_pkg::ST_SEED_MUL: begin
        prod_nxt  = mtg_pkg::SEED_MULT * (prev_r ^ (prev_r >> 30));
        state_nxt = mtg_pkg::ST_SEED_ADD;
      end

      mtg_pkg::ST_SEED_ADD: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = prod_r + 32'(cnt_r);
        prev_nxt  = prod_r + 32'(cnt_r);
        if (cnt_r == mtg_pkg::POS_LAST) begin
          state_nxt = mtg_pkg::ST_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = mtg_pkg::ST_SEED_MUL;
        end
      end

      default: begin
        state_nxt = mtg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_mersenne_twister_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mersenne_twister_generator
// Self-checking bench for the MT19937 generator: seed and draw requests are
// driven with random gaps and stalls, every accepted request is run through a
// local copy of the generator, and each returned word is compared in order.
// ----------------------------------------------------------------------------

module tb_mersenne_twister_generator;

  // --------------------------------------------------------------------------
  // Software copy of the generator plus the queue of words still owed.
  // --------------------------------------------------------------------------
  class mt_scoreboard;
    localparam int unsigned N          = 624;
    localparam int unsigned M          = 397;
    localparam logic [31:0] INIT_MULT  = 32'd1812433253;
    localparam logic [31:0] TWIST_MIX  = 32'h9908_b0df;
    localparam logic [31:0] TOP_BIT    = 32'h8000_0000;
    localparam logic [31:0] REST_BITS  = 32'h7fff_ffff;
    localparam logic [31:0] MASK_B     = 32'h9d2c_5680;
    localparam logic [31:0] MASK_C     = 32'hefc6_0000;

    mtg_pkg::word_t state_words[N];
    int unsigned    read_pos;
    mtg_pkg::word_t owed_words[$];
    int unsigned    mismatches;

    function new();
      read_pos   = N;
      mismatches = 0;
    endfunction

    function void seed_state(mtg_pkg::word_t s);
      state_words[0] = s;
      for (int i = 1; i < N; i++) begin
        state_words[i] = INIT_MULT * (state_words[i-1] ^ (state_words[i-1] >> 30))
                         + mtg_pkg::word_t'(i);
      end
      read_pos = N;
    endfunction

    // full in-place regeneration, same order as the standard algorithm
    function void twist_state();
      mtg_pkg::word_t nxt;
      mtg_pkg::word_t far;
      mtg_pkg::word_t joined;
      mtg_pkg::word_t mixed;
      for (int i = 0; i < N; i++) begin
        nxt    = state_words[(i + 1) % N];
        far    = state_words[(i + M) % N];
        joined = (state_words[i] & TOP_BIT) | (nxt & REST_BITS);
        mixed  = far ^ (joined >> 1);
        if (joined[0]) begin
          mixed = mixed ^ TWIST_MIX;
        end
        state_words[i] = mixed;
      end
      read_pos = 0;
    endfunction

    function mtg_pkg::word_t tempered(mtg_pkg::word_t y_in);
      mtg_pkg::word_t y;
      y = y_in;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & MASK_B);
      y = y ^ ((y << 15) & MASK_C);
      y = y ^ (y >> 18);
      return y;
    endfunction

    function void note_request(logic act, mtg_pkg::word_t seed);
      if (act == mtg_pkg::ACT_SEED) begin
        seed_state(seed);
      end else begin
        if (read_pos >= N) begin
          twist_state();
        end
        owed_words.push_back(tempered(state_words[read_pos]));
        read_pos++;
      end
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_word(mtg_pkg::word_t got);
      mtg_pkg::word_t want;
      if (owed_words.size() == 0) begin
        report_mismatch($sformatf("random_word %h with no draw outstanding", got));
      end else begin
        want = owed_words.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("random_word got %h want %h", got, want));
        end
      end
    endtask

    function int outstanding();
      return owed_words.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_action;
  logic [31:0] in_seed_value;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_random_word;

  mersenne_twister_generator u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_seed_value  (in_seed_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_random_word(out_random_word)
  );

  // Longer than seeding holds the block; used as the settle time at the end.
  localparam int SEED_CYCLES   = 1300;
  // Long receiver hold-off; far longer than the block can buffer.
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 900;

  mt_scoreboard sb;
  int unsigned  requests_sent;
  bit           quiet;          // no idling on either side while set
  bit           hold_off_req;   // asks the receiver for one long stall

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop for a run that never ends.
  initial begin
    #3_000_000;
    $display("tb_mersenne_twister_generator NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, plus one long hold-off on request.
  // Everything changes on the falling edge.
  // --------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 16);
    end
  end

  // Returned words are checked at the rising edge where they are taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_word(out_random_word);
    end
  end

  // --------------------------------------------------------------------------
  // Request side. All tasks are entered and left on a falling edge.
  // --------------------------------------------------------------------------

  // Offer one request and hold it until taken; it is handed to the
  // scoreboard at the accepting edge. Afterwards, maybe leave a gap.
  task automatic send_request(logic act, logic [31:0] seed);
    in_valid      <= 1'b1;
    in_action     <= act;
    in_seed_value <= seed;
    do begin
      @(posedge clk);
    end while (!in_ready);
    sb.note_request(act, seed);
    requests_sent++;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < 16) begin
      in_valid      <= 1'b0;
      in_action     <= 1'($urandom_range(0, 1));
      in_seed_value <= $urandom;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // Stop offering and wait for every owed word to come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  task automatic draw_words(int count);
    for (int i = 0; i < count; i++) begin
      send_request(mtg_pkg::ACT_DRAW, $urandom);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int          seg;
    int          n_draws;
    int          room;
    logic [31:0] seed;

    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_action     = 1'b0;
    in_seed_value = 32'h0;
    quiet         = 1'b0;
    hold_off_req  = 1'b0;
    requests_sent = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed part ----
    // Never draw before the first seed: the state is undefined until then.
    send_request(mtg_pkg::ACT_SEED, 32'h0000_0000);       // all-zero seed
    send_request(mtg_pkg::ACT_DRAW, 32'hffff_ffff);       // seed field ignored
    draw_words(2);
    send_request(mtg_pkg::ACT_SEED, 32'hffff_ffff);       // all-ones seed
    send_request(mtg_pkg::ACT_DRAW, 32'h0000_0000);
    draw_words(1);
    send_request(mtg_pkg::ACT_SEED, 32'd5489);            // the customary default
    draw_words(2);
    // back-to-back seeds: only the second one may count
    send_request(mtg_pkg::ACT_SEED, 32'h1234_5678);
    send_request(mtg_pkg::ACT_SEED, 32'h8765_4321);
    draw_words(1);
    drain_results();                                      // sender pause
    draw_words(2);
    send_request(mtg_pkg::ACT_SEED, 32'h0000_0001);       // reseed mid-stream
    draw_words(1);
    drain_results();

    // ---- random part ----
    // Mostly seed-then-draws segments; the first runs past 624 draws so the
    // state regenerates mid-segment. A few are broken: double seeds, no draws.
    seg = 0;
    while (requests_sent < 17 + RANDOM_ITEMS) begin
      seg++;
      quiet = (seg % 4 == 2);
      case ($urandom_range(0, 5))
        0:       seed = 32'h0000_0000;
        1:       seed = 32'hffff_ffff;
        2:       seed = $urandom_range(0, 15);
        default: seed = $urandom;
      endcase
      send_request(mtg_pkg::ACT_SEED, seed);
      if ($urandom_range(0, 9) == 0) begin
        send_request(mtg_pkg::ACT_SEED, $urandom);
      end
      if (seg == 1) begin
        n_draws = $urandom_range(630, 700);
      end else if ($urandom_range(0, 5) == 0) begin
        n_draws = $urandom_range(620, 700);
      end else if ($urandom_range(0, 7) == 0) begin
        n_draws = 0;
      end else begin
        n_draws = $urandom_range(1, 40);
      end
      // keep the total close to the planned request count
      room = 17 + RANDOM_ITEMS - int'(requests_sent);
      if (n_draws > room) begin
        n_draws = (room > 0) ? room : 0;
      end
      // One long receiver stall while draws keep coming: the block fills up
      // and has to hold off its request side.
      if (seg == 2) begin
        hold_off_req = 1'b1;
        n_draws      = n_draws + 16;
      end
      draw_words(n_draws);
      if ($urandom_range(0, 2) == 0) begin
        drain_results();
      end
    end
    quiet = 1'b0;

    // ---- wind-down ----
    drain_results();
    repeat (SEED_CYCLES) @(negedge clk);

    if (sb.mismatches == 0) begin
      $display("tb_mersenne_twister_generator OK");
    end else begin
      $display("tb_mersenne_twister_generator NOT OK");
    end
    $finish;
  end

endmodule
